// ===== rtl/fpr_pkg.sv =====
// Shared types, widths, status codes and helper functions for the fast-packet reassembler.
// No dependencies. Every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package fpr_pkg;

    localparam int CAN_ID_W     = 29;
    localparam int DLC_W        = 4;
    localparam int BYTE_W       = 8;
    localparam int PGN_W        = 18;
    localparam int SRC_W        = 8;
    localparam int SEQ_W        = 3;
    localparam int FIDX_W       = 5;
    localparam int EXP_FRAME_W  = 6;
    localparam int LEN_W        = 8;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 3;
    localparam int OUT_LANES    = 7;
    localparam int IN_BYTES     = 8;

    localparam int FIRST_FRAME_BYTES = 6;
    localparam int NEXT_FRAME_BYTES  = 7;

    // Config bus
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_MAX_PACKET_LEN = 2'd0;
    localparam logic [LEN_W-1:0] MAX_PACKET_LEN_RESET = 8'd223;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STARTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PROGRESS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd4;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PGN_W-1:0]    packet_pgn;
        logic [SRC_W-1:0]    packet_source;
        logic [LEN_W-1:0]    write_offset;
        logic [COUNT_W-1:0]  write_count;
        byte_t [OUT_LANES-1:0] lanes;
    } result_t;

    // J1939 identifier layout: PDU2 formats (PF >= 240) keep PS in the PGN
    function automatic logic [PGN_W-1:0] pgn_of(input logic [CAN_ID_W-1:0] id);
        logic [7:0] pf;
        logic [7:0] ps;
        pf = id[23:16];
        ps = id[15:8];
        pgn_of = {id[25], id[24], pf, (pf >= 8'd240) ? ps : 8'd0};
    endfunction

endpackage

// ===== rtl/fpr_frame_if.sv =====
// Channel interfaces: CAN frame beats in, reassembly result beats out.
// Depends on fpr_pkg for field widths.
`timescale 1ns / 1ps

interface fpr_frame_if import fpr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CAN_ID_W-1:0] can_id;
    logic                is_extended;
    logic [DLC_W-1:0]    frame_len;
    logic [BYTE_W-1:0]   byte0;
    logic [BYTE_W-1:0]   byte1;
    logic [BYTE_W-1:0]   byte2;
    logic [BYTE_W-1:0]   byte3;
    logic [BYTE_W-1:0]   byte4;
    logic [BYTE_W-1:0]   byte5;
    logic [BYTE_W-1:0]   byte6;
    logic [BYTE_W-1:0]   byte7;

    modport source (
        output valid, can_id, is_extended, frame_len,
        output byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
        input  ready
    );
    modport sink (
        input  valid, can_id, is_extended, frame_len,
        input  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
        output ready
    );
endinterface

interface fpr_result_if import fpr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PGN_W-1:0]    packet_pgn;
    logic [SRC_W-1:0]    packet_source;
    logic [LEN_W-1:0]    write_offset;
    logic [COUNT_W-1:0]  write_count;
    logic [BYTE_W-1:0]   out_byte0;
    logic [BYTE_W-1:0]   out_byte1;
    logic [BYTE_W-1:0]   out_byte2;
    logic [BYTE_W-1:0]   out_byte3;
    logic [BYTE_W-1:0]   out_byte4;
    logic [BYTE_W-1:0]   out_byte5;
    logic [BYTE_W-1:0]   out_byte6;

    modport source (
        output valid, status, packet_pgn, packet_source, write_offset, write_count,
        output out_byte0, out_byte1, out_byte2, out_byte3, out_byte4, out_byte5,
        output out_byte6,
        input  ready
    );
    modport sink (
        input  valid, status, packet_pgn, packet_source, write_offset, write_count,
        input  out_byte0, out_byte1, out_byte2, out_byte3, out_byte4, out_byte5,
        input  out_byte6,
        output ready
    );
endinterface

// ===== rtl/fast_packet_reassembler.sv =====
// Fast-packet reassembler top level: frame decode, packet tracking state and result register.
// Depends on fpr_pkg and the channel interfaces in fpr_frame_if.sv.
// Channel   Dir  Handshake        Payload
// frames    in   valid/ready      can_id, is_extended, frame_len, byte0..byte7
// results   out  valid/ready      status, pgn, source, offset, count, out_byte0..6
// apb       in   psel/penable     max_packet_len at byte address 0
//
// Every frame beat yields exactly one result beat, registered in the cycle after it is accepted.
// Throughput is one frame per cycle while results are taken: the tracking state updates at
// the same edge that loads the result register, so the next frame sees it immediately.
// frames.ready drops only while the result register holds a beat that is not taken.
// rst_n clears the tracking state, the result valid flag and restores max_packet_len to 223.
`timescale 1ns / 1ps

module fast_packet_reassembler
    import fpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fpr_frame_if.sink             frames,
    fpr_result_if.source          results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [LEN_W-1:0] max_len_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_PACKET_LEN_RESET;
        end
        else if (psel && penable && pwrite && (paddr == REG_MAX_PACKET_LEN))
        begin
            max_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_MAX_PACKET_LEN)
        begin
            prdata = {{(APB_DATA_W-LEN_W){1'b0}}, max_len_reg};
        end
    end

    // ---------------------------------------------------------------
    // Packet tracking state
    // ---------------------------------------------------------------
    logic                   busy_reg,      busy_next;
    logic [SEQ_W-1:0]       cur_seq_reg,   cur_seq_next;
    logic [SRC_W-1:0]       cur_src_reg,   cur_src_next;
    logic [PGN_W-1:0]       cur_pgn_reg,   cur_pgn_next;
    logic [LEN_W-1:0]       exp_len_reg,   exp_len_next;
    logic [LEN_W-1:0]       bytes_reg,     bytes_next;
    logic [EXP_FRAME_W-1:0] exp_frame_reg, exp_frame_next;

    // Result register; one beat deep, refilled in the cycle it drains
    logic    res_valid_reg;
    result_t res_reg, res_next;

    logic accept;
    assign frames.ready = !res_valid_reg || results.ready;
    assign accept       = frames.valid && frames.ready;

    // ---------------------------------------------------------------
    // Frame decode
    // ---------------------------------------------------------------
    byte_t [IN_BYTES-1:0] d;
    logic [SRC_W-1:0]     src;
    logic [PGN_W-1:0]     pgn;
    logic [SEQ_W-1:0]     seq;
    logic [FIDX_W-1:0]    fidx;
    logic [LEN_W-1:0]     total;
    logic                 ignore_frame;
    logic                 first_ok;
    logic                 cont_match;
    logic [LEN_W-1:0]     remaining;
    logic [COUNT_W-1:0]   n_first;
    logic [COUNT_W-1:0]   n_cont;
    logic [LEN_W-1:0]     bytes_cont;

    assign d = {frames.byte7, frames.byte6, frames.byte5, frames.byte4,
                frames.byte3, frames.byte2, frames.byte1, frames.byte0};

    assign src   = frames.can_id[SRC_W-1:0];
    assign pgn   = pgn_of(frames.can_id);
    assign seq   = frames.byte0[7:5];
    assign fidx  = frames.byte0[FIDX_W-1:0];
    assign total = frames.byte1;

    // Standard frames and frames without a header plus one byte carry nothing for us
    assign ignore_frame = !frames.is_extended || (frames.frame_len < 4'd2);
    assign first_ok     = (total != '0) && (total <= max_len_reg);
    assign cont_match   = busy_reg && (seq == cur_seq_reg) && (src == cur_src_reg)
                          && (pgn == cur_pgn_reg);

    // Busy implies bytes_reg < exp_len_reg, so remaining is never zero when used
    assign remaining  = exp_len_reg - bytes_reg;
    assign n_first    = (total < LEN_W'(FIRST_FRAME_BYTES)) ? total[COUNT_W-1:0]
                                                            : COUNT_W'(FIRST_FRAME_BYTES);
    assign n_cont     = (remaining < LEN_W'(NEXT_FRAME_BYTES)) ? remaining[COUNT_W-1:0]
                                                               : COUNT_W'(NEXT_FRAME_BYTES);
    assign bytes_cont = bytes_reg + {{(LEN_W-COUNT_W){1'b0}}, n_cont};

    // ---------------------------------------------------------------
    // Next state and result
    // ---------------------------------------------------------------
    always_comb
    begin
        busy_next      = busy_reg;
        cur_seq_next   = cur_seq_reg;
        cur_src_next   = cur_src_reg;
        cur_pgn_next   = cur_pgn_reg;
        exp_len_next   = exp_len_reg;
        bytes_next     = bytes_reg;
        exp_frame_next = exp_frame_reg;
        res_next       = '0;
        res_next.status = ST_IGNORED;

        if (!ignore_frame)
        begin
            if (fidx == '0)
            begin
                if (!first_ok)
                begin
                    // Bad total length: flag it, leave any packet in flight alone
                    res_next.status = ST_ERROR;
                end
                else
                begin
                    // A good first frame always restarts assembly
                    cur_seq_next   = seq;
                    cur_src_next   = src;
                    cur_pgn_next   = pgn;
                    exp_len_next   = total;
                    bytes_next     = {{(LEN_W-COUNT_W){1'b0}}, n_first};
                    exp_frame_next = EXP_FRAME_W'(1);
                    if (total <= LEN_W'(FIRST_FRAME_BYTES))
                    begin
                        busy_next       = 1'b0;
                        res_next.status = ST_COMPLETE;
                    end
                    else
                    begin
                        busy_next       = 1'b1;
                        res_next.status = ST_STARTED;
                    end
                    res_next.packet_pgn    = pgn;
                    res_next.packet_source = src;
                    res_next.write_offset  = '0;
                    res_next.write_count   = n_first;
                    // Payload starts after the header and total length bytes
                    for (int i = 0; i < OUT_LANES - 1; i++)
                    begin
                        if (COUNT_W'(i) < n_first)
                        begin
                            res_next.lanes[i] = d[i+2];
                        end
                    end
                end
            end
            else if (cont_match)
            begin
                if ({1'b0, fidx} != exp_frame_reg)
                begin
                    // Lost or repeated frame: drop the packet
                    busy_next       = 1'b0;
                    cur_seq_next    = '0;
                    cur_src_next    = '0;
                    cur_pgn_next    = '0;
                    exp_len_next    = '0;
                    bytes_next      = '0;
                    exp_frame_next  = '0;
                    res_next.status = ST_ERROR;
                end
                else
                begin
                    bytes_next     = bytes_cont;
                    exp_frame_next = exp_frame_reg + EXP_FRAME_W'(1);
                    if (bytes_cont >= exp_len_reg)
                    begin
                        busy_next       = 1'b0;
                        res_next.status = ST_COMPLETE;
                    end
                    else
                    begin
                        res_next.status = ST_PROGRESS;
                    end
                    res_next.packet_pgn    = cur_pgn_reg;
                    res_next.packet_source = cur_src_reg;
                    res_next.write_offset  = bytes_reg;
                    res_next.write_count   = n_cont;
                    // Payload follows the header byte
                    for (int i = 0; i < OUT_LANES; i++)
                    begin
                        if (COUNT_W'(i) < n_cont)
                        begin
                            res_next.lanes[i] = d[i+1];
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cur_seq_reg   <= '0;
            cur_src_reg   <= '0;
            cur_pgn_reg   <= '0;
            exp_len_reg   <= '0;
            bytes_reg     <= '0;
            exp_frame_reg <= '0;
        end
        else if (accept)
        begin
            busy_reg      <= busy_next;
            cur_seq_reg   <= cur_seq_next;
            cur_src_reg   <= cur_src_next;
            cur_pgn_reg   <= cur_pgn_next;
            exp_len_reg   <= exp_len_next;
            bytes_reg     <= bytes_next;
            exp_frame_reg <= exp_frame_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Payload holds while the sink stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // ---------------------------------------------------------------
    // Result channel
    // ---------------------------------------------------------------
    assign results.valid         = res_valid_reg;
    assign results.status        = res_reg.status;
    assign results.packet_pgn    = res_reg.packet_pgn;
    assign results.packet_source = res_reg.packet_source;
    assign results.write_offset  = res_reg.write_offset;
    assign results.write_count   = res_reg.write_count;
    assign results.out_byte0     = res_reg.lanes[0];
    assign results.out_byte1     = res_reg.lanes[1];
    assign results.out_byte2     = res_reg.lanes[2];
    assign results.out_byte3     = res_reg.lanes[3];
    assign results.out_byte4     = res_reg.lanes[4];
    assign results.out_byte5     = res_reg.lanes[5];
    assign results.out_byte6     = res_reg.lanes[6];

endmodule

// ===== test/fast_packet_reassembler_tb.sv =====
// Self-checking bench for fast_packet_reassembler: CAN frame beats in, result beats out.
// Depends on fpr_pkg, the channel interfaces in rtl/fpr_frame_if.sv and the RTL top level.
`timescale 1ns / 1ps

module fast_packet_reassembler_tb;
    import fpr_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int REPORT_LIMIT    = 10;

    // One CAN frame as the sender sees it
    typedef struct packed {
        logic [CAN_ID_W-1:0]  can_id;
        logic                 is_extended;
        logic [DLC_W-1:0]     frame_len;
        byte_t [IN_BYTES-1:0] data;
    } frame_t;

    // Receiver ready patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_HALF,
        RX_QUARTER
    } rx_pattern_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fpr_frame_if  frm ();
    fpr_result_if res ();

    fast_packet_reassembler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frames  (frm),
        .results (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // Frames waiting to be offered, and predicted result beats in acceptance order
    frame_t  frames_to_send[$];
    result_t reassembly_due[$];

    int mismatches    = 0;
    int packet_frames = 0;
    int hold_requests = 0;

    // Shadow of max_packet_len and of the packet tracking state
    byte_t                  len_limit    = MAX_PACKET_LEN_RESET;
    logic                   asm_busy     = 1'b0;
    logic [SEQ_W-1:0]       asm_seq      = '0;
    logic [SRC_W-1:0]       asm_src      = '0;
    logic [PGN_W-1:0]       asm_pgn      = '0;
    byte_t                  asm_total    = '0;
    byte_t                  asm_filled   = '0;
    logic [EXP_FRAME_W-1:0] asm_next_idx = '0;

    // ------------------------------------------------------------------
    // Predictor: one accepted frame in, one result beat out. Updates the
    // shadow tracking state exactly as the block must.
    // ------------------------------------------------------------------
    function automatic result_t reassemble(frame_t f);
        result_t          r;
        logic [SRC_W-1:0] src;
        logic [PGN_W-1:0] pgn;
        logic [7:0]       pf;
        logic [SEQ_W-1:0] seq;
        logic [FIDX_W-1:0] idx;
        int unsigned      take;
        int unsigned      room;
        int unsigned      start_lane;
        byte_t            offset;
        int               i;
        r = '0;
        // Standard frames and frames under two bytes carry nothing for us
        if (!f.is_extended || f.frame_len < 2)
            return r;
        src = f.can_id[7:0];
        pf  = f.can_id[23:16];
        // PDU2 formats keep PS in the PGN, PDU1 formats drop it
        pgn = {f.can_id[25:24], pf, (pf >= 8'd240) ? f.can_id[15:8] : 8'h00};
        seq = f.data[0][7:5];
        idx = f.data[0][4:0];
        if (idx == 0) begin
            // Bad total length: error, tracking state left alone
            if (f.data[1] == 0 || f.data[1] > len_limit) begin
                r.status = ST_ERROR;
                return r;
            end
            // A good first frame always restarts, even mid-packet
            asm_busy     = 1'b1;
            asm_seq      = seq;
            asm_src      = src;
            asm_pgn      = pgn;
            asm_total    = f.data[1];
            take         = (f.data[1] < FIRST_FRAME_BYTES) ? f.data[1] : FIRST_FRAME_BYTES;
            offset       = '0;
            start_lane   = 2;
            asm_filled   = byte_t'(take);
            asm_next_idx = EXP_FRAME_W'(1);
            r.status     = ST_STARTED;
        end
        else begin
            // Continuations of some other packet, or while idle, are ignored
            if (!asm_busy || seq != asm_seq || src != asm_src || pgn != asm_pgn)
                return r;
            // Out of order: drop the packet. An index of 32 can never match.
            if ({1'b0, idx} != asm_next_idx) begin
                asm_busy     = 1'b0;
                asm_seq      = '0;
                asm_src      = '0;
                asm_pgn      = '0;
                asm_total    = '0;
                asm_filled   = '0;
                asm_next_idx = '0;
                r.status     = ST_ERROR;
                return r;
            end
            room         = asm_total - asm_filled;
            take         = (room < NEXT_FRAME_BYTES) ? room : NEXT_FRAME_BYTES;
            offset       = asm_filled;
            start_lane   = 1;
            asm_filled   = byte_t'(asm_filled + take);
            asm_next_idx = asm_next_idx + 1'b1;
            r.status     = ST_PROGRESS;
        end
        // Completion clears busy only; the rest of the state stays
        if (asm_filled >= asm_total) begin
            asm_busy = 1'b0;
            r.status = ST_COMPLETE;
        end
        r.packet_pgn    = asm_pgn;
        r.packet_source = asm_src;
        r.write_offset  = offset;
        r.write_count   = take[COUNT_W-1:0];
        // Lanes at or past write_count stay zero
        for (i = 0; i < take && i < OUT_LANES; i++)
            if (start_lane + i < IN_BYTES)
                r.lanes[i] = f.data[start_lane + i];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------
    function automatic frame_t build_frame(logic [CAN_ID_W-1:0] id, logic ext,
                                           logic [DLC_W-1:0] dlc, byte_t hdr, byte_t b1);
        frame_t f;
        int     i;
        f.can_id      = id;
        f.is_extended = ext;
        f.frame_len   = dlc;
        for (i = 2; i < IN_BYTES; i++)
            f.data[i] = byte_t'($urandom);
        f.data[0] = hdr;
        f.data[1] = b1;
        return f;
    endfunction

    // Mostly full frames, sometimes short or over-long length codes
    function automatic logic [DLC_W-1:0] random_dlc();
        return ($urandom_range(0, 3) != 0) ? 4'd8 : 4'($urandom_range(2, 15));
    endfunction

    function automatic frame_t noise_frame();
        return build_frame(CAN_ID_W'($urandom), 1'($urandom), DLC_W'($urandom_range(0, 15)),
                           byte_t'($urandom), byte_t'($urandom));
    endfunction

    // Queue one well-formed packet with random content, now and then broken:
    // stray frames slipped in, foreign sequence numbers, frames out of order,
    // packets abandoned and overrun by the next first frame.
    task automatic queue_packet();
        logic [CAN_ID_W-1:0] id;
        logic [SEQ_W-1:0]    seq;
        logic [FIDX_W-1:0]   idx;
        byte_t               total;
        int                  frames;
        int                  k;
        int                  pick;
        id   = CAN_ID_W'($urandom);
        seq  = SEQ_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 6)
            total = byte_t'($urandom_range(1, 30));
        else if (pick < 8)
            total = byte_t'($urandom);
        else
            total = byte_t'(len_limit + $urandom_range(0, 1));
        frames = (total <= FIRST_FRAME_BYTES) ? 1 :
                 1 + (total - FIRST_FRAME_BYTES + NEXT_FRAME_BYTES - 1) / NEXT_FRAME_BYTES;
        // Past index 31 the first continuation already fails, so stop there
        if (frames > 33)
            frames = 33;
        if ($urandom_range(0, 9) == 0)
            frames_to_send.push_back(noise_frame());
        frames_to_send.push_back(build_frame(id, 1'b1, random_dlc(), {seq, 5'd0}, total));
        packet_frames++;
        for (k = 1; k < frames; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                frames_to_send.push_back(noise_frame());
            else if (pick < 7)
                frames_to_send.push_back(build_frame(id, 1'b1, random_dlc(),
                                                     {seq + 3'd1, 5'(k)}, byte_t'($urandom)));
            else if (pick >= 95 && pick < 97)
                break;
            idx = (k >= 32) ? 5'($urandom_range(1, 31)) : 5'(k);
            if (pick >= 97)
                idx = (k > 1 && pick == 99) ? 5'(k - 1) : (k < 31 ? 5'(k + 1) : 5'(k - 1));
            frames_to_send.push_back(build_frame(id, 1'b1, random_dlc(), {seq, idx},
                                                 byte_t'($urandom)));
            packet_frames++;
            if (pick >= 97)
                break;
        end
    endtask

    // ------------------------------------------------------------------
    // Frame driver: bursts of random length with random gaps. Predict each
    // frame at the edge where it is accepted.
    // ------------------------------------------------------------------
    frame_t on_wire;
    int     burst_left = 1;
    int     gap_left   = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            frm.valid <= 1'b0;
        end
        else begin
            if (frm.valid && frm.ready)
                reassembly_due.push_back(reassemble(on_wire));
            // Hold the current beat until taken; only then advance
            if (!frm.valid || frm.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    frm.valid <= 1'b0;
                end
                else if (frames_to_send.size() > 0) begin
                    on_wire = frames_to_send.pop_front();
                    frm.valid       <= 1'b1;
                    frm.can_id      <= on_wire.can_id;
                    frm.is_extended <= on_wire.is_extended;
                    frm.frame_len   <= on_wire.frame_len;
                    frm.byte0       <= on_wire.data[0];
                    frm.byte1       <= on_wire.data[1];
                    frm.byte2       <= on_wire.data[2];
                    frm.byte3       <= on_wire.data[3];
                    frm.byte4       <= on_wire.data[4];
                    frm.byte5       <= on_wire.data[5];
                    frm.byte6       <= on_wire.data[6];
                    frm.byte7       <= on_wire.data[7];
                    if (burst_left > 1) begin
                        burst_left--;
                    end
                    else begin
                        // Long gapless runs now and then, short gaps otherwise
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else begin
                    frm.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each beat with the oldest prediction and
    // drive ready on a changing pattern, plus the long hold-off on request.
    // ------------------------------------------------------------------
    result_t     got;
    result_t     want;
    int          beats_seen  = 0;
    int          hold_served = 0;
    int          hold_left   = 0;
    int          mode_left   = 0;
    int unsigned rx_tick     = 0;
    rx_pattern_t rx_mode     = RX_ALWAYS;

    always @(posedge clk) begin
        if (!rst_n) begin
            res.ready <= 1'b0;
        end
        else begin
            if (res.valid && res.ready) begin
                beats_seen++;
                got.status        = res.status;
                got.packet_pgn    = res.packet_pgn;
                got.packet_source = res.packet_source;
                got.write_offset  = res.write_offset;
                got.write_count   = res.write_count;
                got.lanes         = {res.out_byte6, res.out_byte5, res.out_byte4,
                                     res.out_byte3, res.out_byte2, res.out_byte1,
                                     res.out_byte0};
                if (reassembly_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat %0d with nothing predicted, status %0d",
                                 $time, beats_seen, got.status);
                end
                else begin
                    want = reassembly_due.pop_front();
                    if (got.status !== want.status || got.packet_pgn !== want.packet_pgn ||
                        got.packet_source !== want.packet_source ||
                        got.write_offset !== want.write_offset ||
                        got.write_count !== want.write_count || got.lanes !== want.lanes) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: result beat %0d mismatch", $time, beats_seen);
                            $display("  expected status %0d pgn %h src %h off %0d cnt %0d lanes %h",
                                     want.status, want.packet_pgn, want.packet_source,
                                     want.write_offset, want.write_count, want.lanes);
                            $display("  actual   status %0d pgn %h src %h off %0d cnt %0d lanes %h",
                                     got.status, got.packet_pgn, got.packet_source,
                                     got.write_offset, got.write_count, got.lanes);
                        end
                    end
                end
            end

            // Pick up a hold-off request and count it down here
            if (hold_served != hold_requests) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_served++;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_pattern_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            else begin
                mode_left--;
            end
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else begin
                case (rx_mode)
                    RX_ALWAYS:  res.ready <= 1'b1;
                    RX_RANDOM:  res.ready <= ($urandom_range(0, 9) > 2);
                    RX_HALF:    res.ready <= rx_tick[0];
                    RX_QUARTER: res.ready <= (rx_tick[1:0] == 2'd0);
                    default:    res.ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog: too many cycles in a row with no beat accepted on either side
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (frm.valid && frm.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("** fast_packet_reassembler: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Configuration access
    // ------------------------------------------------------------------

    // Wait until every queued frame is taken and every result has come back
    task automatic wait_drained();
        while (frames_to_send.size() != 0 || frm.valid || reassembly_due.size() != 0)
            @(posedge clk);
    endtask

    // Read max_packet_len back and check it
    task automatic check_max_len(byte_t value);
        logic [APB_DATA_W-1:0] word;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_MAX_PACKET_LEN;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        word = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (word !== {{(APB_DATA_W - LEN_W){1'b0}}, value}) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: max_packet_len read expected %0d got %h", $time, value, word);
        end
    endtask

    // Write max_packet_len once the block is idle; junk in the upper data bits
    task automatic write_max_len(byte_t value);
        logic [APB_DATA_W-1:0] word;
        wait_drained();
        repeat (2) @(posedge clk);
        word       = $urandom;
        word[7:0]  = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_PACKET_LEN;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        len_limit = value;
        check_max_len(value);
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    localparam logic [CAN_ID_W-1:0] ID_PDU2  = 29'h19F2_0A17;
    localparam logic [CAN_ID_W-1:0] ID_PDU1  = 29'h0DE1_1234;
    localparam logic [CAN_ID_W-1:0] ID_ONES  = 29'h1FFF_FFFF;
    localparam logic [CAN_ID_W-1:0] ID_PF240 = 29'h00F0_5501;
    localparam logic [CAN_ID_W-1:0] ID_PF239 = 29'h00EF_5501;

    initial begin
        byte_t settings[5];
        int    quota[5];
        int    p;

        // Every input known from time zero
        rst_n           = 1'b0;
        frm.valid       = 1'b0;
        frm.can_id      = '0;
        frm.is_extended = 1'b0;
        frm.frame_len   = '0;
        frm.byte0       = '0;
        frm.byte1       = '0;
        frm.byte2       = '0;
        frm.byte3       = '0;
        frm.byte4       = '0;
        frm.byte5       = '0;
        frm.byte6       = '0;
        frm.byte7       = '0;
        res.ready       = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        check_max_len(MAX_PACKET_LEN_RESET);

        // Directed frames at the reset limit of 223
        // ignored: standard frame, too short, empty
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b0, 4'd8, 8'h00, 8'd10));
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd1, 8'h00, 8'd10));
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd0, 8'h00, 8'd10));
        // bad totals: zero, one past the limit, the maximum byte
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd8, 8'h00, 8'd0));
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd8, 8'h00, 8'd224));
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd8, 8'h00, 8'd255));
        // continuation while idle
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd8, 8'h21, 8'h5A));
        // single-frame packets: one byte with an over-long length code, six bytes
        frames_to_send.push_back(build_frame('0, 1'b1, 4'd15, 8'h00, 8'd1));
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd8, 8'h00, 8'd6));
        // 20-byte packet, sequence 3, with foreign continuations mixed in
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd8, 8'h60, 8'd20));
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd8, 8'h41, 8'hA5));
        frames_to_send.push_back(build_frame(ID_PDU2 ^ 29'h1, 1'b1, 4'd8, 8'h61, 8'hA5));
        frames_to_send.push_back(build_frame(ID_PDU2 ^ 29'h100, 1'b1, 4'd8, 8'h61, 8'hA5));
        // right frame with a two-byte length code still delivers seven bytes
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd2, 8'h61, 8'hC3));
        // frame 3 where 2 is due: error, packet dropped
        frames_to_send.push_back(build_frame(ID_PDU2, 1'b1, 4'd8, 8'h63, 8'hC3));
        // full-length packet, then interrupted by a new first frame
        frames_to_send.push_back(build_frame(ID_ONES, 1'b1, 4'd8, 8'hE0, 8'd223));
        frames_to_send.push_back(build_frame(ID_ONES, 1'b1, 4'd8, 8'hE1, 8'hFF));
        frames_to_send.push_back(build_frame(ID_PDU1, 1'b1, 4'd8, 8'h20, 8'd13));
        frames_to_send.push_back(build_frame(ID_PDU1, 1'b1, 4'd8, 8'h21, 8'h11));
        // continuation after completion is ignored
        frames_to_send.push_back(build_frame(ID_PDU1, 1'b1, 4'd8, 8'h22, 8'h22));
        // short tail: two bytes in the last frame, upper lanes zero
        frames_to_send.push_back(build_frame(ID_PDU1, 1'b1, 4'd8, 8'h40, 8'd8));
        frames_to_send.push_back(build_frame(ID_PDU1, 1'b1, 4'd8, 8'h41, 8'h33));
        // PF on either side of the PDU2 boundary
        frames_to_send.push_back(build_frame(ID_PF240, 1'b1, 4'd8, 8'h00, 8'd2));
        frames_to_send.push_back(build_frame(ID_PF239, 1'b1, 4'd8, 8'h00, 8'd3));

        // Random packets at the reset limit; hold the receiver off meanwhile
        // so the result register fills and the frame side stalls
        packet_frames = 0;
        while (packet_frames < 200)
            queue_packet();
        hold_requests++;

        // Further limits: over-range, both low extremes, a middle value, back to 223
        settings = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(7, 60)), MAX_PACKET_LEN_RESET};
        quota    = '{190, 150, 40, 180, 180};
        for (p = 0; p < 5; p++) begin
            write_max_len(settings[p]);
            packet_frames = 0;
            while (packet_frames < quota[p])
                queue_packet();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && reassembly_due.size() == 0)
            $display("** fast_packet_reassembler: PASSED **");
        else
            $display("** fast_packet_reassembler: FAILED **");
        $finish;
    end

endmodule
